### design/lfe_pkg.sv
package lfe_pkg;

    localparam int INDEX_BITS_DEF = 28;

    // APB register map, byte address 4 * index.
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_FADE_OUT    = 3'd0;
    localparam logic [2:0] REG_FORCE       = 3'd1;
    localparam logic [2:0] REG_GAIN        = 3'd2;
    localparam logic [2:0] REG_RAMP_STEP   = 3'd3;
    localparam logic [2:0] REG_WHOLE_RANGE = 3'd4;
    localparam logic [2:0] REG_START_FRAME = 3'd5;
    localparam logic [2:0] REG_END_FRAME   = 3'd6;
    localparam logic [2:0] REG_CHANNELS    = 3'd7;

    localparam logic [16:0] FORCE_RST    = 17'd65536;
    localparam logic [19:0] GAIN_RST     = 20'd65536;
    localparam logic [3:0]  CHANNELS_RST = 4'd2;

    // Envelope is signed Q4.32.
    localparam int ENV_W = 37;
    localparam logic signed [ENV_W-1:0] ENV_ONE = 37'sh0_1_0000_0000;
    localparam logic signed [ENV_W-1:0] ENV_MAX = 37'sh0F_FFFF_FFFF;
    localparam logic signed [ENV_W-1:0] ENV_MIN = 37'sh10_0000_0000;

    // Shared multiplier operand widths.
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 19;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic        fade_out;
        logic [16:0] force_q16;
        logic [19:0] gain_q16;
        logic [31:0] ramp_step_q32;
        logic        whole_range;
        logic [27:0] start_frame;
        logic [27:0] end_frame;
        logic [3:0]  channels;
    } lfe_cfg_t;

    typedef struct packed {
        logic signed [15:0] sample_in;
        logic               first;
    } lfe_in_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               in_range;
    } lfe_out_t;

endpackage

### design/linear_fade_envelope.sv
// Linear fade envelope for interleaved signed 16-bit audio.
// Items enter on the s_ channel (s_valid/s_ready, payload s_data) and leave on
// the m_ channel (m_valid/m_ready, payload m_data), one result item per input
// item, in order. Settings are to be written by the user over the APB port only
// while the block idles; the block itself does not enforce this. An in-range
// item is scaled by envelope times gain on one shared multiplier in three passes:
// |sample| * gain, then that product times the low and the high half of
// |envelope|. The first pass runs in the idle state as the item is accepted, the
// other two in S_LO and S_HI, and the sum, truncation and saturation in S_DONE,
// which registers the result. An out-of-range item bypasses the multiplier and
// goes from acceptance straight to S_DONE. s_ready is high only between items.
// The result sits in an output register; when the receiver stalls, the next
// result waits in its final step until that register is taken.
// Reset (aresetn low, synchronous) restores the register defaults and clears
// the sample index and the envelope; the envelope is loaded on an item marked
// first.
module linear_fade_envelope #(
    parameter int INDEX_BITS = lfe_pkg::INDEX_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  lfe_pkg::lfe_in_t           s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output lfe_pkg::lfe_out_t          m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lfe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LO   = 2'd1;
    localparam logic [1:0] S_HI   = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam int ENV_W  = lfe_pkg::ENV_W;
    localparam int A_W    = lfe_pkg::MUL_A_W;
    localparam int B_W    = lfe_pkg::MUL_B_W;
    localparam int P_W    = lfe_pkg::PROD_W;
    localparam int SUM_W  = P_W + B_W;
    localparam int E_LO_W = B_W;

    lfe_pkg::lfe_cfg_t cfg;

    logic [1:0]               state_reg, state_next;
    logic [INDEX_BITS-1:0]    idx_reg;
    logic signed [ENV_W-1:0]  env_reg;
    logic signed [15:0]       sample_reg;
    logic                     s_neg_reg;
    logic                     hit_reg;
    logic [A_W-1:0]           t_reg;
    logic [P_W-1:0]           acc_reg;
    logic                     m_valid_reg;
    lfe_pkg::lfe_out_t        m_data_reg;

    logic                     accept;
    logic [INDEX_BITS-1:0]    idx_eff;
    logic [31:0]              range_lo, range_hi;
    logic                     hit_now;
    logic [15:0]              sm_now;
    logic signed [17:0]       force_diff;
    logic signed [ENV_W-1:0]  env_load;
    logic [ENV_W-1:0]         env_mag;
    logic signed [ENV_W:0]    env_upd;
    logic signed [ENV_W-1:0]  env_step;
    logic                     mul_load;
    logic [A_W-1:0]           mul_a;
    logic [B_W-1:0]           mul_b;
    logic [P_W-1:0]           prod;
    logic [SUM_W-1:0]         sum;
    logic [SUM_W-49:0]        q;
    logic                     res_neg;
    logic signed [15:0]       scaled;
    logic                     out_free;

    lfe_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lfe_mul u_mul (
        .aclk (aclk),
        .load (mul_load),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Index and range test for the item at the input.
    assign idx_eff  = s_data.first ? '0 : idx_reg;
    assign range_lo = 32'(cfg.start_frame) * 32'(cfg.channels);
    assign range_hi = 32'(cfg.end_frame) * 32'(cfg.channels);
    assign hit_now  = cfg.whole_range ||
                      ((32'(idx_eff) >= range_lo) && (32'(idx_eff) <= range_hi));
    assign sm_now   = s_data.sample_in[15] ? 16'(-s_data.sample_in)
                                           : 16'(s_data.sample_in);

    // A fade-in starts at one minus force; force above one gives a negative start.
    assign force_diff = 18'sd65536 - $signed({1'b0, cfg.force_q16});
    assign env_load   = cfg.fade_out ? lfe_pkg::ENV_ONE
                                     : {{3{force_diff[17]}}, force_diff, 16'b0};

    assign env_mag = env_reg[ENV_W-1] ? ENV_W'(-env_reg) : ENV_W'(env_reg);

    always_comb begin
        if (cfg.fade_out) begin
            env_upd = {env_reg[ENV_W-1], env_reg} - $signed({6'b0, cfg.ramp_step_q32});
        end else begin
            env_upd = {env_reg[ENV_W-1], env_reg} + $signed({6'b0, cfg.ramp_step_q32});
        end
        if (env_upd[ENV_W] != env_upd[ENV_W-1]) begin
            env_step = env_upd[ENV_W] ? lfe_pkg::ENV_MIN : lfe_pkg::ENV_MAX;
        end else begin
            env_step = env_upd[ENV_W-1:0];
        end
    end

    // Operand selection for the shared multiplier.
    assign mul_load = (state_reg != S_DONE);
    always_comb begin
        unique case (state_reg)
            S_IDLE: begin
                mul_a = A_W'(cfg.gain_q16);
                mul_b = B_W'(sm_now);
            end
            S_LO: begin
                mul_a = prod[A_W-1:0];
                mul_b = env_mag[E_LO_W-1:0];
            end
            S_HI: begin
                mul_a = t_reg;
                mul_b = B_W'(env_mag[ENV_W-1:E_LO_W]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Final sum of the two partial products, then truncation and saturation.
    assign sum     = SUM_W'(acc_reg) + {prod, {E_LO_W{1'b0}}};
    assign q       = sum[SUM_W-1:48];
    assign res_neg = s_neg_reg ^ env_reg[ENV_W-1];
    always_comb begin
        if (res_neg) begin
            scaled = (q > (SUM_W-48)'(32768)) ? -16'sd32768 : 16'(-q[15:0]);
        end else begin
            scaled = (q > (SUM_W-48)'(32767)) ? 16'sd32767 : $signed(q[15:0]);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = hit_now ? S_LO : S_DONE;
                end
            end
            S_LO:   state_next = S_HI;
            S_HI:   state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            idx_reg     <= '0;
            env_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                idx_reg <= (idx_eff != {INDEX_BITS{1'b1}}) ? idx_eff + INDEX_BITS'(1)
                                                           : idx_eff;
                if (s_data.first) begin
                    env_reg <= env_load;
                end
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
                if (hit_reg) begin
                    env_reg <= env_step;
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_data.sample_in;
            s_neg_reg  <= s_data.sample_in[15];
            hit_reg    <= hit_now;
        end
        if (state_reg == S_LO) begin
            t_reg <= prod[A_W-1:0];
        end
        if (state_reg == S_HI) begin
            acc_reg <= prod;
        end
        if (state_reg == S_DONE && out_free) begin
            m_data_reg.sample_out <= hit_reg ? scaled : sample_reg;
            m_data_reg.in_range   <= hit_reg;
        end
    end

    a_miss_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !hit_now) |=> (state_reg == S_DONE))
        else $error("out-of-range item did not bypass the multiplier");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared outside the final step");

    a_env_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LO || state_reg == S_HI) |=> $stable(env_reg))
        else $error("envelope changed during the multiply passes");

endmodule

### design/lfe_regs.sv
module lfe_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lfe_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output lfe_pkg::lfe_cfg_t          cfg
);

    lfe_pkg::lfe_cfg_t cfg_reg;
    logic              wr_en;
    logic [2:0]        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.fade_out      <= 1'b0;
            cfg_reg.force_q16     <= lfe_pkg::FORCE_RST;
            cfg_reg.gain_q16      <= lfe_pkg::GAIN_RST;
            cfg_reg.ramp_step_q32 <= '0;
            cfg_reg.whole_range   <= 1'b1;
            cfg_reg.start_frame   <= '0;
            cfg_reg.end_frame     <= '0;
            cfg_reg.channels      <= lfe_pkg::CHANNELS_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                lfe_pkg::REG_FADE_OUT:    cfg_reg.fade_out      <= pwdata[0];
                lfe_pkg::REG_FORCE:       cfg_reg.force_q16     <= pwdata[16:0];
                lfe_pkg::REG_GAIN:        cfg_reg.gain_q16      <= pwdata[19:0];
                lfe_pkg::REG_RAMP_STEP:   cfg_reg.ramp_step_q32 <= pwdata;
                lfe_pkg::REG_WHOLE_RANGE: cfg_reg.whole_range   <= pwdata[0];
                lfe_pkg::REG_START_FRAME: cfg_reg.start_frame   <= pwdata[27:0];
                lfe_pkg::REG_END_FRAME:   cfg_reg.end_frame     <= pwdata[27:0];
                lfe_pkg::REG_CHANNELS:    cfg_reg.channels      <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            lfe_pkg::REG_FADE_OUT:    prdata = {31'b0, cfg_reg.fade_out};
            lfe_pkg::REG_FORCE:       prdata = {15'b0, cfg_reg.force_q16};
            lfe_pkg::REG_GAIN:        prdata = {12'b0, cfg_reg.gain_q16};
            lfe_pkg::REG_RAMP_STEP:   prdata = cfg_reg.ramp_step_q32;
            lfe_pkg::REG_WHOLE_RANGE: prdata = {31'b0, cfg_reg.whole_range};
            lfe_pkg::REG_START_FRAME: prdata = {4'b0, cfg_reg.start_frame};
            lfe_pkg::REG_END_FRAME:   prdata = {4'b0, cfg_reg.end_frame};
            lfe_pkg::REG_CHANNELS:    prdata = {28'b0, cfg_reg.channels};
            default:                  prdata = '0;
        endcase
    end

endmodule

### design/lfe_mul.sv
module lfe_mul (
    input  logic                        aclk,
    input  logic                        load,
    input  logic [lfe_pkg::MUL_A_W-1:0] a,
    input  logic [lfe_pkg::MUL_B_W-1:0] b,
    output logic [lfe_pkg::PROD_W-1:0]  prod
);

    logic [lfe_pkg::PROD_W-1:0] prod_reg;

    assign prod = prod_reg;

    // Unsigned multiply with a registered product; holds while load is low.
    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg <= lfe_pkg::PROD_W'(a) * lfe_pkg::PROD_W'(b);
        end
    end

endmodule

### test/tb_linear_fade_envelope.sv
module tb_linear_fade_envelope;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     QUIET_LIMIT  = 2000;
    localparam int     RANDOM_ITEMS = 1200;
    localparam int     CALM_FROM    = 1000;
    localparam longint IDX_TOP      = (longint'(1) << lfe_pkg::INDEX_BITS_DEF) - 1;

    logic                       aclk    = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    lfe_pkg::lfe_in_t           s_data  = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    lfe_pkg::lfe_out_t          m_data;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [lfe_pkg::ADDR_W-1:0] paddr   = '0;
    logic [31:0]                pwdata  = '0;
    logic [31:0]                prdata;
    logic                       pready;

    lfe_pkg::lfe_in_t  sample_feed[$];
    lfe_pkg::lfe_out_t awaited[$];

    // Shadow copy of the block's settings and running state.
    lfe_pkg::lfe_cfg_t shadow_cfg;
    longint            frame_pos;
    longint            env_level;

    int mismatches   = 0;
    int results_seen = 0;
    int quiet_cycles = 0;
    int feed_gap     = 0;
    int sink_stall   = 0;
    bit steady       = 1'b0;
    bit s_taken      = 1'b0;

    linear_fade_envelope dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin : clock_gen
        forever #2 aclk = ~aclk;
    end

    function automatic longint env_clip(longint v);
        if (v > longint'(lfe_pkg::ENV_MAX)) return longint'(lfe_pkg::ENV_MAX);
        if (v < longint'(lfe_pkg::ENV_MIN)) return longint'(lfe_pkg::ENV_MIN);
        return v;
    endfunction

    // Computes the output for one sample and advances index and envelope.
    function automatic lfe_pkg::lfe_out_t fade_sample(lfe_pkg::lfe_in_t item);
        longint            smp;
        longint            res;
        longint            q;
        logic [63:0]       smag;
        logic [63:0]       emag;
        logic [79:0]       prod;
        logic              neg;
        logic              hit;
        lfe_pkg::lfe_out_t r;
        smp = longint'(signed'(item.sample_in));
        res = smp;
        if (item.first) begin
            frame_pos = 0;
            if (shadow_cfg.fade_out) begin
                env_level = longint'(lfe_pkg::ENV_ONE);
            end else begin
                env_level = env_clip((65536 - longint'(shadow_cfg.force_q16)) * 65536);
            end
        end
        if (shadow_cfg.whole_range) begin
            hit = 1'b1;
        end else begin
            hit = frame_pos >= longint'(shadow_cfg.start_frame) * longint'(shadow_cfg.channels)
               && frame_pos <= longint'(shadow_cfg.end_frame) * longint'(shadow_cfg.channels);
        end
        if (hit) begin
            // Exact product of magnitudes, truncated, then the sign applied.
            neg  = (smp < 0) != (env_level < 0);
            smag = (smp < 0) ? -smp : smp;
            emag = (env_level < 0) ? -env_level : env_level;
            prod = 80'(smag);
            prod = prod * emag * shadow_cfg.gain_q16;
            q    = longint'(prod >> 48);
            if (neg) begin
                res = (q > 32768) ? -32768 : -q;
            end else begin
                res = (q > 32767) ? 32767 : q;
            end
            if (shadow_cfg.fade_out) begin
                env_level = env_clip(env_level - longint'(shadow_cfg.ramp_step_q32));
            end else begin
                env_level = env_clip(env_level + longint'(shadow_cfg.ramp_step_q32));
            end
        end
        if (frame_pos < IDX_TOP) frame_pos++;
        r.sample_out = res[15:0];
        r.in_range   = hit;
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        mismatches++;
        $display("%0t ns result %0d: %s is %0d, expected %0d",
                 $time, results_seen, what, got, want);
    endtask

    // Sample driver: holds each item until it is taken, with random gaps between items unless steady is set.
    always @(negedge aclk) begin : feed
        lfe_pkg::lfe_in_t nxt_data;
        logic             nxt_valid;
        nxt_valid = s_valid;
        nxt_data  = s_data;
        if (!s_valid || s_taken) begin
            nxt_valid = 1'b0;
            if (feed_gap > 0) begin
                feed_gap--;
            end else if (sample_feed.size() > 0) begin
                nxt_data  = sample_feed.pop_front();
                nxt_valid = 1'b1;
                if (!steady && $urandom_range(0, 6) == 0) feed_gap = $urandom_range(1, 10);
            end
        end
        s_valid <= nxt_valid;
        s_data  <= nxt_data;
    end

    always @(negedge aclk) begin : sink
        if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= 1'b0;
        end else if (!steady && $urandom_range(0, 8) == 0) begin
            sink_stall = $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : observe
        lfe_pkg::lfe_out_t want;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[lfe_pkg::ADDR_W-1:2])
                    lfe_pkg::REG_FADE_OUT:    shadow_cfg.fade_out      = pwdata[0];
                    lfe_pkg::REG_FORCE:       shadow_cfg.force_q16     = pwdata[16:0];
                    lfe_pkg::REG_GAIN:        shadow_cfg.gain_q16      = pwdata[19:0];
                    lfe_pkg::REG_RAMP_STEP:   shadow_cfg.ramp_step_q32 = pwdata;
                    lfe_pkg::REG_WHOLE_RANGE: shadow_cfg.whole_range   = pwdata[0];
                    lfe_pkg::REG_START_FRAME: shadow_cfg.start_frame   = pwdata[27:0];
                    lfe_pkg::REG_END_FRAME:   shadow_cfg.end_frame     = pwdata[27:0];
                    lfe_pkg::REG_CHANNELS:    shadow_cfg.channels      = pwdata[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) awaited = {awaited, fade_sample(s_data)};
            if (m_valid && m_ready) begin
                if (awaited.size() == 0) begin
                    flag_mismatch("item with no sample pending", 1, 0);
                end else begin
                    want = awaited.pop_front();
                    if (m_data.sample_out !== want.sample_out) begin
                        flag_mismatch("sample_out", int'(signed'(m_data.sample_out)),
                                      int'(signed'(want.sample_out)));
                    end
                    if (m_data.in_range !== want.in_range) begin
                        flag_mismatch("in_range", int'(m_data.in_range), int'(want.in_range));
                    end
                end
                results_seen++;
            end
        end
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("** linear_fade_envelope: FAILED **");
        $finish;
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_settings(lfe_pkg::lfe_cfg_t c);
        write_reg(lfe_pkg::REG_FADE_OUT,    32'(c.fade_out));
        write_reg(lfe_pkg::REG_FORCE,       32'(c.force_q16));
        write_reg(lfe_pkg::REG_GAIN,        32'(c.gain_q16));
        write_reg(lfe_pkg::REG_RAMP_STEP,   c.ramp_step_q32);
        write_reg(lfe_pkg::REG_WHOLE_RANGE, 32'(c.whole_range));
        write_reg(lfe_pkg::REG_START_FRAME, 32'(c.start_frame));
        write_reg(lfe_pkg::REG_END_FRAME,   32'(c.end_frame));
        write_reg(lfe_pkg::REG_CHANNELS,    32'(c.channels));
    endtask

    // Waits until every queued sample has been taken and every result checked.
    task automatic settle();
        while (sample_feed.size() != 0 || s_valid || awaited.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic add_sample(int v, bit f);
        lfe_pkg::lfe_in_t item;
        item.sample_in = v[15:0];
        item.first     = f;
        sample_feed = {sample_feed, item};
    endtask

    function automatic int rand_sample();
        case ($urandom_range(0, 11))
            0:       return 32767;
            1:       return -32768;
            2:       return 0;
            3:       return -1;
            default: return int'(signed'(16'($urandom)));
        endcase
    endfunction

    function automatic lfe_pkg::lfe_cfg_t pick_settings();
        lfe_pkg::lfe_cfg_t c;
        c.fade_out = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0:       c.force_q16 = '0;
            1:       c.force_q16 = lfe_pkg::FORCE_RST;
            2:       c.force_q16 = 17'h1FFFF;
            3:       c.force_q16 = 17'($urandom_range(0, 65536));
            default: c.force_q16 = 17'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       c.gain_q16 = '0;
            1:       c.gain_q16 = lfe_pkg::GAIN_RST;
            2:       c.gain_q16 = 20'hFFFFF;
            3:       c.gain_q16 = 20'($urandom_range(0, 20'h3FFFF));
            default: c.gain_q16 = 20'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0:       c.ramp_step_q32 = '0;
            1:       c.ramp_step_q32 = 32'hFFFF_FFFF;
            2:       c.ramp_step_q32 = 32'h8000_0000;
            3:       c.ramp_step_q32 = $urandom;
            default: c.ramp_step_q32 = $urandom_range(0, 32'h0800_0000);
        endcase
        c.whole_range = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0:       c.start_frame = 28'hFFF_FFFF;
            1:       c.start_frame = 28'($urandom);
            default: c.start_frame = 28'($urandom_range(0, 6));
        endcase
        case ($urandom_range(0, 7))
            0:       c.end_frame = 28'hFFF_FFFF;
            1:       c.end_frame = 28'($urandom);
            default: c.end_frame = 28'($urandom_range(0, 14));
        endcase
        case ($urandom_range(0, 7))
            0:       c.channels = '0;
            1:       c.channels = 4'($urandom);
            default: c.channels = 4'($urandom_range(1, 8));
        endcase
        return c;
    endfunction

    initial begin : stimulus
        lfe_pkg::lfe_cfg_t c;
        int                total;
        int                len;
        bit                marked;
        shadow_cfg               = '0;
        shadow_cfg.force_q16     = lfe_pkg::FORCE_RST;
        shadow_cfg.gain_q16      = lfe_pkg::GAIN_RST;
        shadow_cfg.whole_range   = 1'b1;
        shadow_cfg.channels      = lfe_pkg::CHANNELS_RST;
        frame_pos                = 0;
        env_level                = 0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Without a first mark the envelope is still zero after reset.
        add_sample(32767, 1'b0);
        add_sample(-32768, 1'b0);
        add_sample(1, 1'b0);
        settle();

        // Force above one gives a negative start; maximum gain drives saturation.
        c               = '0;
        c.force_q16     = 17'h1FFFF;
        c.gain_q16      = 20'hFFFFF;
        c.ramp_step_q32 = 32'h8000_0000;
        c.whole_range   = 1'b1;
        c.channels      = lfe_pkg::CHANNELS_RST;
        load_settings(c);
        add_sample(32767, 1'b1);
        add_sample(-32768, 1'b0);
        add_sample(1, 1'b0);
        add_sample(-1, 1'b0);
        add_sample(0, 1'b0);
        add_sample(12345, 1'b0);
        settle();

        // Frame range 1..2 with three channels covers indexes 3 to 6.
        c.fade_out      = 1'b1;
        c.force_q16     = '0;
        c.gain_q16      = lfe_pkg::GAIN_RST;
        c.ramp_step_q32 = 32'h1000_0000;
        c.whole_range   = 1'b0;
        c.start_frame   = 28'd1;
        c.end_frame     = 28'd2;
        c.channels      = 4'd3;
        load_settings(c);
        for (int i = 0; i < 8; i++) add_sample(rand_sample(), i == 0);
        settle();

        // With zero channels only index zero lies in range.
        c.channels    = '0;
        c.start_frame = 28'd5;
        c.end_frame   = 28'd7;
        load_settings(c);
        for (int i = 0; i < 3; i++) add_sample(rand_sample(), i == 0);
        settle();

        // Start above end leaves the range empty.
        c.channels    = 4'd1;
        c.start_frame = 28'd3;
        c.end_frame   = 28'd1;
        load_settings(c);
        for (int i = 0; i < 3; i++) add_sample(rand_sample(), i == 0);
        settle();

        // Random settings, each followed by a few files of samples. Most files open
        // with a first mark; a few continue the previous one or restart midway.
        total = 0;
        while (total < RANDOM_ITEMS) begin
            settle();
            steady = (total >= CALM_FROM) || ($urandom_range(0, 4) == 0);
            load_settings(pick_settings());
            repeat ($urandom_range(1, 3)) begin
                len    = $urandom_range(3, 40);
                marked = $urandom_range(0, 9) != 0;
                for (int i = 0; i < len; i++) begin
                    add_sample(rand_sample(),
                               (marked && i == 0) || $urandom_range(0, 49) == 0);
                end
                total += len;
            end
        end
        settle();
        repeat (8) @(posedge aclk);

        if (mismatches == 0) begin
            $display("** linear_fade_envelope: PASSED **");
        end else begin
            $display("** linear_fade_envelope: FAILED **");
        end
        $finish;
    end

endmodule
